/* rtl/core/skjc_pkg.sv */
`default_nettype none
package skjc_pkg;

  localparam int unsigned AgeW   = 12;
  localparam int unsigned GapW   = 10;
  localparam int unsigned LevelW = 8;
  localparam int unsigned PulseW = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 8;

  localparam logic [AgeW-1:0]   AgeMax      = {AgeW{1'b1}};
  localparam logic [GapW-1:0]   GapMax      = {GapW{1'b1}};
  localparam logic [LevelW-1:0] LevelWindow = 8'd10;
  localparam logic [GapW-1:0]   MinGapReset = 10'd200;
  localparam logic [AgeW-1:0]   ExpireReset = 12'd2000;

  typedef enum logic [1:0] {
    ActTick       = 2'd0,
    ActAdd        = 2'd1,
    ActAddForced  = 2'd2,
    ActUnused     = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    StIdle     = 3'd0,
    StWaiting  = 3'd1,
    StAccepted = 3'd2,
    StRejected = 3'd3,
    StTooSoon  = 3'd4,
    StExpired  = 3'd5,
    StFiring   = 3'd6,
    StDone     = 3'd7
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegMaxCharge   = 3'd0,
    RegAutoRecharge = 3'd1,
    RegMinGap      = 3'd2,
    RegExpire      = 3'd3,
    RegVoltTol     = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [LevelW-1:0] max_charge_level;
    logic              auto_recharge;
    logic [GapW-1:0]   min_gap_ms;
    logic [AgeW-1:0]   expire_ms;
    logic [LevelW-1:0] voltage_tolerance;
  } cfg_t;

  typedef struct packed {
    status_e status;
    logic    booster_restart;
    logic    booster_inhibit;
    logic    move_permit;
    logic    release_res;
  } result_t;

endpackage
`default_nettype wire

/* rtl/core/solenoid_kick_job_controller.sv */
// Each result beat is registered in the output register, or in the skid on a stall.
// One beat per cycle while the skid is empty; the job state updates once at acceptance.
// A two-entry output stage (register plus skid) keeps input flowing under short stalls.
// Reset (rst_ni low, asynchronous): job state cleared, output stage empty,
// registers return to max 0, auto recharge off, gap 200 ms, expiry 2000 ms, tolerance 0.
`default_nettype none
module solenoid_kick_job_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [skjc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [skjc_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // pulse_ms[7:0], force_level[15:8], cap_voltage[23:16], kick_safe[24],
  // booster_ready[25], aligned[26], rotor_locked[27], zero fill
  input  wire logic [skjc_pkg::InDataW-1:0]  s_axis_tdata,
  // action[1:0]
  input  wire logic [1:0]                    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // release_res[0], move_permit[1], booster_inhibit[2], booster_restart[3],
  // status[6:4], zero fill
  output logic [skjc_pkg::OutDataW-1:0]      m_axis_tdata
);

  skjc_pkg::cfg_t    cfg;
  skjc_pkg::result_t res_new;
  skjc_pkg::result_t res_out;
  logic              in_ready;
  logic              fire;

  assign fire          = s_axis_tvalid && in_ready;
  assign s_axis_tready = in_ready;

  skjc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  skjc_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .fire_i          (fire),
    .action_i        (s_axis_tuser),
    .pulse_ms_i      (s_axis_tdata[7:0]),
    .force_level_i   (s_axis_tdata[15:8]),
    .cap_voltage_i   (s_axis_tdata[23:16]),
    .kick_safe_i     (s_axis_tdata[24]),
    .booster_ready_i (s_axis_tdata[25]),
    .aligned_i       (s_axis_tdata[26]),
    .rotor_locked_i  (s_axis_tdata[27]),
    .res_o           (res_new)
  );

  skjc_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (fire),
    .res_i        (res_new),
    .ready_o      (in_ready),
    .valid_o      (m_axis_tvalid),
    .take_ready_i (m_axis_tready),
    .res_o        (res_out)
  );

  assign m_axis_tdata = {1'b0, res_out};

endmodule
`default_nettype wire

/* rtl/core/skjc_cfg.sv */
`default_nettype none
module skjc_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [skjc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [skjc_pkg::CfgDataW-1:0] cfg_data_i,
  output skjc_pkg::cfg_t                     cfg_o
);

  skjc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        skjc_pkg::RegMaxCharge:    cfg_d.max_charge_level  = cfg_data_i[7:0];
        skjc_pkg::RegAutoRecharge: cfg_d.auto_recharge     = cfg_data_i[0];
        skjc_pkg::RegMinGap:       cfg_d.min_gap_ms        = cfg_data_i[9:0];
        skjc_pkg::RegExpire:       cfg_d.expire_ms         = cfg_data_i[11:0];
        skjc_pkg::RegVoltTol:      cfg_d.voltage_tolerance = cfg_data_i[7:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_charge_level  <= '0;
      cfg_q.auto_recharge     <= 1'b0;
      cfg_q.min_gap_ms        <= skjc_pkg::MinGapReset;
      cfg_q.expire_ms         <= skjc_pkg::ExpireReset;
      cfg_q.voltage_tolerance <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* rtl/core/skjc_core.sv */
`default_nettype none
module skjc_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire skjc_pkg::cfg_t              cfg_i,
  input  wire logic                        fire_i,
  input  wire logic [1:0]                  action_i,
  input  wire logic [skjc_pkg::PulseW-1:0] pulse_ms_i,
  input  wire logic [skjc_pkg::LevelW-1:0] force_level_i,
  input  wire logic [skjc_pkg::LevelW-1:0] cap_voltage_i,
  input  wire logic                        kick_safe_i,
  input  wire logic                        booster_ready_i,
  input  wire logic                        aligned_i,
  input  wire logic                        rotor_locked_i,
  output skjc_pkg::result_t                res_o
);

  logic                        pending_q, pending_d;
  logic [skjc_pkg::AgeW-1:0]   age_q, age_d;
  logic [skjc_pkg::GapW-1:0]   gap_q, gap_d;
  logic [skjc_pkg::PulseW-1:0] plen_q, plen_d;
  logic [skjc_pkg::LevelW-1:0] flev_q, flev_d;
  logic                        firing_q, firing_d;
  logic [skjc_pkg::PulseW-1:0] pleft_q, pleft_d;

  logic [skjc_pkg::AgeW-1:0]   age_inc;
  logic [skjc_pkg::GapW-1:0]   gap_inc;
  logic [skjc_pkg::PulseW-1:0] pleft_dec;
  logic [skjc_pkg::LevelW-1:0] vdiff;
  logic                        level_bad;
  logic                        drive;
  skjc_pkg::action_e           act;

  assign act       = skjc_pkg::action_e'(action_i);
  assign age_inc   = (age_q < skjc_pkg::AgeMax) ? age_q + 1'b1 : age_q;
  assign gap_inc   = (gap_q < skjc_pkg::GapMax) ? gap_q + 1'b1 : gap_q;
  assign pleft_dec = (pleft_q != '0) ? pleft_q - 1'b1 : pleft_q;
  assign vdiff     = (flev_q > cap_voltage_i) ? flev_q - cap_voltage_i
                                              : cap_voltage_i - flev_q;
  assign level_bad = (force_level_i > cfg_i.max_charge_level) ||
                     ((cfg_i.max_charge_level >= skjc_pkg::LevelWindow) &&
                      (force_level_i < cfg_i.max_charge_level - skjc_pkg::LevelWindow));

  always_comb begin
    pending_d = pending_q;
    age_d     = age_q;
    gap_d     = gap_q;
    plen_d    = plen_q;
    flev_d    = flev_q;
    firing_d  = firing_q;
    pleft_d   = pleft_q;
    drive     = 1'b0;
    res_o.booster_restart = 1'b0;
    res_o.status          = skjc_pkg::StIdle;

    if (act != skjc_pkg::ActTick) begin
      if (firing_q) begin
        drive        = 1'b1;
        res_o.status = skjc_pkg::StFiring;
      end else begin
        unique case (act)
          skjc_pkg::ActAdd: begin
            plen_d       = pulse_ms_i;
            age_d        = '0;
            pending_d    = 1'b1;
            res_o.status = skjc_pkg::StAccepted;
          end
          skjc_pkg::ActAddForced: begin
            if (level_bad) begin
              res_o.status = skjc_pkg::StRejected;
            end else begin
              plen_d       = pulse_ms_i;
              flev_d       = force_level_i;
              age_d        = '0;
              pending_d    = 1'b1;
              res_o.status = skjc_pkg::StAccepted;
            end
          end
          default: begin
            res_o.status = pending_q ? skjc_pkg::StWaiting : skjc_pkg::StIdle;
          end
        endcase
      end
    end else begin
      age_d = age_inc;
      gap_d = gap_inc;
      if (firing_q) begin
        pleft_d = pleft_dec;
        if (pleft_dec == '0) begin
          firing_d  = 1'b0;
          pending_d = 1'b0;
          gap_d     = '0;
          res_o.booster_restart = cfg_i.auto_recharge;
          res_o.status          = skjc_pkg::StDone;
        end else begin
          drive        = 1'b1;
          res_o.status = skjc_pkg::StFiring;
        end
      end else if (!pending_q) begin
        res_o.status = skjc_pkg::StIdle;
      end else if (!kick_safe_i) begin
        res_o.status = skjc_pkg::StWaiting;
      end else if (gap_inc < cfg_i.min_gap_ms) begin
        pending_d    = 1'b0;
        res_o.status = skjc_pkg::StTooSoon;
      end else if ((flev_q != '0) && (vdiff > cfg_i.voltage_tolerance)) begin
        res_o.status = skjc_pkg::StWaiting;
      end else begin
        flev_d = '0;
        if (age_inc > cfg_i.expire_ms) begin
          pending_d    = 1'b0;
          res_o.status = skjc_pkg::StExpired;
        end else if (!booster_ready_i || !aligned_i || !rotor_locked_i) begin
          res_o.status = skjc_pkg::StWaiting;
        end else if (plen_q == '0) begin
          pending_d = 1'b0;
          gap_d     = '0;
          pleft_d   = '0;
          res_o.booster_restart = cfg_i.auto_recharge;
          res_o.status          = skjc_pkg::StDone;
        end else begin
          firing_d     = 1'b1;
          pleft_d      = plen_q;
          drive        = 1'b1;
          res_o.status = skjc_pkg::StFiring;
        end
      end
    end

    res_o.release_res     = drive;
    res_o.booster_inhibit = drive;
    res_o.move_permit     = !drive;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      age_q     <= '0;
      gap_q     <= '0;
      plen_q    <= '0;
      flev_q    <= '0;
      firing_q  <= 1'b0;
      pleft_q   <= '0;
    end else if (fire_i) begin
      pending_q <= pending_d;
      age_q     <= age_d;
      gap_q     <= gap_d;
      plen_q    <= plen_d;
      flev_q    <= flev_d;
      firing_q  <= firing_d;
      pleft_q   <= pleft_d;
    end
  end

`ifndef SYNTH
  a_fire_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    firing_q |-> (pleft_q != '0))
    else $error("firing with no pulse left");
  a_fire_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    firing_q |-> pending_q)
    else $error("firing without a pending job");
`endif

endmodule
`default_nettype wire

/* rtl/core/skjc_out.sv */
`default_nettype none
module skjc_out (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire skjc_pkg::result_t res_i,
  output logic                   ready_o,
  output logic                   valid_o,
  input  wire logic              take_ready_i,
  output skjc_pkg::result_t      res_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  skjc_pkg::result_t out_q, out_d;
  skjc_pkg::result_t skid_q, skid_d;
  logic              drain;

  assign drain   = !out_valid_q || take_ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign res_o   = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (drain) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = push_i;
        skid_d       = res_i;
      end else begin
        out_valid_d = push_i;
        out_d       = res_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

`ifndef SYNTH
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid beat held with empty output stage");
  a_hold_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !take_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled output beat changed");
`endif

endmodule
`default_nettype wire
